/* rtl/rtsa_pkg.sv */
// Shared types, codes and helper functions for the radix tree sparse array.
package rtsa_pkg;

  localparam int unsigned FANOUT  = 16;
  localparam int unsigned NIB_W   = 4;
  localparam int unsigned LEVEL_W = 3;
  localparam int unsigned LEN_W   = 31;
  localparam logic [LEN_W-1:0] LEN_MAX = 31'h7FFF_FFFF;
  localparam logic [LEN_W-1:0] DIRECT_COUNT = 31'd16;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_SET = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_NEG  = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  typedef struct packed {
    command_e           command;
    logic signed [31:0] index;
    logic [31:0]        write_value;
  } req_t;

  typedef struct packed {
    logic [31:0]      read_value;
    status_e          status;
    logic [LEN_W-1:0] current_length;
  } rsp_t;

  // root number: position of the highest nonzero nibble, at least 1
  function automatic logic [LEVEL_W-1:0] root_of(logic [LEN_W-1:0] u);
    logic [LEVEL_W-1:0] k;
    if (|u[30:28]) k = 3'd7;
    else if (|u[27:24]) k = 3'd6;
    else if (|u[23:20]) k = 3'd5;
    else if (|u[19:16]) k = 3'd4;
    else if (|u[15:12]) k = 3'd3;
    else if (|u[11:8]) k = 3'd2;
    else k = 3'd1;
    return k;
  endfunction

  function automatic logic [NIB_W-1:0] nib(logic [LEN_W-1:0] u, logic [LEVEL_W-1:0] lvl);
    logic [31:0] w;
    w = {1'b0, u};
    return w[{lvl, 2'b00} +: NIB_W];
  endfunction

endpackage

/* rtl/rtsa_if.sv */
// Valid/ready channel carrying one word of type T.
interface rtsa_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/radix_tree_sparse_array_top.sv */
// Sparse array of 32-bit values held as a 16-way radix tree in one node memory.
//
// Request channel req_i carries a word {command, index, write_value}; response
// channel rsp_o returns one word {read_value, status, current_length} per
// request, in order. Indices 0..15 sit in direct registers; larger ones walk
// k+1 nodes of the pool from root k (k = nibble count - 1, 1..7).
// Direct slots, negative indices and reads past the length go from S_EVAL
// straight to S_DONE; a tree read passes S_WALK once per level and then
// S_LEAF; a tree write walks the same way and adds missing nodes in S_CHAIN
// and S_LEAFW. One request is in work at a time: the node memory has one
// port and each level needs the previous level's read data.
// A new request is taken while the previous response still waits in the
// output register; a stalled receiver holds that register and, once the next
// request is done, holds the engine in its final state until the slot frees.
// Reset clears direct slots, roots and length and sets the free-node counter
// to 1 at once, then sweeps the node memory to zero one entry per cycle, all
// NODE_COUNT*16 entries, during which req_i.ready stays low.
module radix_tree_sparse_array_top
  import rtsa_pkg::*;
#(
  parameter int unsigned NODE_COUNT = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rtsa_if.sink         req_i,
  rtsa_if.source       rsp_o
);

  localparam int unsigned DEPTH  = NODE_COUNT * FANOUT;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned PTR_W  = $clog2(NODE_COUNT);
  localparam int unsigned CNT_W  = $clog2(NODE_COUNT + 1);
  localparam int unsigned SUM_W  = CNT_W + 4;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EVAL  = 7'b0000010,
    S_WALK  = 7'b0000100,
    S_LEAF  = 7'b0001000,
    S_CHAIN = 7'b0010000,
    S_LEAFW = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] pool_mem [DEPTH];
  logic [31:0] rdata_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [31:0]       mem_wdata;

  logic              clr_q;
  logic [ADDR_W-1:0] clr_addr_q;

  logic [31:0]      dir_q [FANOUT];
  logic [PTR_W-1:0] root_q [8];
  logic             dir_we, root_we;

  logic [CNT_W-1:0]   nf_q, nf_d;
  logic [LEN_W-1:0]   len_q, len_d;
  req_t               req_q, req_d;
  logic [LEVEL_W-1:0] k_q, k_d, lvl_q, lvl_d;
  logic               first_q, first_d;
  logic [ADDR_W-1:0]  par_q, par_d;
  logic [PTR_W-1:0]   node_q, node_d;
  logic [31:0]        rv_q, rv_d;
  status_e            st_q, st_d;
  logic               grow_q, grow_d;
  logic               out_valid_q, out_load;
  rsp_t               out_q;

  logic [LEN_W-1:0]  u;
  logic [31:0]       cur;
  logic              cur_ok;
  logic [ADDR_W-1:0] walk_addr;
  logic [SUM_W-1:0]  need_sum;

  assign u         = req_q.index[LEN_W-1:0];
  assign cur       = first_q ? 32'(root_q[k_q]) : rdata_q;
  assign cur_ok    = (cur != 32'd0) && (cur < 32'(NODE_COUNT));
  assign walk_addr = {cur[PTR_W-1:0], nib(u, lvl_q)};
  assign need_sum  = SUM_W'(nf_q) + SUM_W'(lvl_q) + SUM_W'(1);

  assign req_i.ready = (state_q == S_IDLE) && !clr_q;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    k_d       = k_q;
    lvl_d     = lvl_q;
    first_d   = first_q;
    par_d     = par_q;
    node_d    = node_q;
    rv_d      = rv_q;
    st_d      = st_q;
    grow_d    = grow_q;
    nf_d      = nf_q;
    len_d     = len_q;
    mem_we    = 1'b0;
    mem_waddr = clr_addr_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = walk_addr;
    dir_we    = 1'b0;
    root_we   = 1'b0;
    out_load  = 1'b0;

    if (clr_q) begin
      mem_we = 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid && req_i.ready) begin
          req_d   = req_i.data;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        rv_d    = '0;
        st_d    = STATUS_OK;
        grow_d  = 1'b0;
        k_d     = root_of(u);
        lvl_d   = root_of(u);
        first_d = 1'b1;
        if (req_q.index[31]) begin
          st_d    = STATUS_NEG;
          state_d = S_DONE;
        end else if (req_q.command == CMD_GET) begin
          if (u >= len_q) begin
            state_d = S_DONE;
          end else if (u < DIRECT_COUNT) begin
            rv_d    = dir_q[u[NIB_W-1:0]];
            state_d = S_DONE;
          end else begin
            state_d = S_WALK;
          end
        end else begin
          if (u < DIRECT_COUNT) begin
            dir_we  = 1'b1;
            grow_d  = 1'b1;
            state_d = S_DONE;
          end else begin
            state_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (cur_ok) begin
          if (lvl_q == '0) begin
            if (req_q.command == CMD_GET) begin
              mem_re  = 1'b1;
              state_d = S_LEAF;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = walk_addr;
              mem_wdata = req_q.write_value;
              grow_d    = 1'b1;
              state_d   = S_DONE;
            end
          end else begin
            mem_re  = 1'b1;
            par_d   = walk_addr;
            lvl_d   = lvl_q - 3'd1;
            first_d = 1'b0;
          end
        end else if (req_q.command == CMD_GET) begin
          state_d = S_DONE;
        end else if (need_sum > SUM_W'(NODE_COUNT)) begin
          st_d    = STATUS_FULL;
          state_d = S_DONE;
        end else begin
          if (first_q) begin
            root_we = 1'b1;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = par_q;
            mem_wdata = 32'(nf_q);
          end
          node_d  = nf_q[PTR_W-1:0];
          nf_d    = nf_q + CNT_W'(1);
          state_d = (lvl_q == '0) ? S_LEAFW : S_CHAIN;
        end
      end
      S_LEAF: begin
        rv_d    = rdata_q;
        state_d = S_DONE;
      end
      S_CHAIN: begin
        mem_we    = 1'b1;
        mem_waddr = {node_q, nib(u, lvl_q)};
        mem_wdata = 32'(nf_q);
        node_d    = nf_q[PTR_W-1:0];
        nf_d      = nf_q + CNT_W'(1);
        lvl_d     = lvl_q - 3'd1;
        if (lvl_q == 3'd1) begin
          state_d = S_LEAFW;
        end
      end
      S_LEAFW: begin
        mem_we    = 1'b1;
        mem_waddr = {node_q, nib(u, 3'd0)};
        mem_wdata = req_q.write_value;
        grow_d    = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          if (grow_q && (u >= len_q)) begin
            len_d = (u == LEN_MAX) ? LEN_MAX : u + 31'd1;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pool_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= pool_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FANOUT; i++) begin
        dir_q[i] <= '0;
      end
      for (int i = 0; i < 8; i++) begin
        root_q[i] <= '0;
      end
    end else begin
      if (dir_we) begin
        dir_q[u[NIB_W-1:0]] <= req_q.write_value;
      end
      if (root_we) begin
        root_q[k_q] <= nf_q[PTR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nf_q        <= CNT_W'(1);
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      nf_q    <= nf_d;
      len_q   <= len_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    k_q     <= k_d;
    lvl_q   <= lvl_d;
    first_q <= first_d;
    par_q   <= par_d;
    node_q  <= node_d;
    rv_q    <= rv_d;
    st_q    <= st_d;
    grow_q  <= grow_d;
    if (out_load) begin
      out_q.read_value     <= rv_q;
      out_q.status         <= st_q;
      out_q.current_length <= len_d;
    end
  end

  a_nf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nf_q <= CNT_W'(NODE_COUNT))
    else $error("free-node counter passed the pool size");

  a_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("node memory read and written in one cycle");

  a_len_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q >= $past(len_q))
    else $error("array length decreased");

  a_link_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHAIN) |-> (nf_q < CNT_W'(NODE_COUNT)))
    else $error("node allocated beyond the pool");

  a_idle_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> (state_q == S_IDLE) && !out_valid_q)
    else $error("request in work during memory clear");

endmodule

/* verif/tb.sv */
// Self-checking testbench for the radix tree sparse array: predicts each response and compares.
`timescale 1ns / 100ps

module tb
  import rtsa_pkg::*;
();

  localparam int unsigned NODES = 1024;
  localparam int unsigned QUIET_LIMIT = 100000;
  localparam int unsigned DRAIN_CYCLES = 40;

  class rtsa_scoreboard;
    logic [31:0]      slot_copy [16];
    logic [31:0]      node_copy [NODES*FANOUT];
    int unsigned      root_copy [8];
    int unsigned      free_node;
    logic [LEN_W-1:0] length_copy;
    rsp_t             want_q [$];
    int               errors;

    function new();
      foreach (slot_copy[i]) slot_copy[i] = '0;
      foreach (node_copy[i]) node_copy[i] = '0;
      foreach (root_copy[i]) root_copy[i] = 0;
      free_node   = 1;
      length_copy = '0;
      errors      = 0;
    endfunction

    function int unsigned depth_of(logic [LEN_W-1:0] u);
      int unsigned k;
      k = 1;
      while (k < 7 && (u >> (4*(k+1))) != 0) k++;
      return k;
    endfunction

    function int unsigned digit(logic [LEN_W-1:0] u, int unsigned lvl);
      logic [31:0] w;
      w = {1'b0, u};
      return 32'(w[4*lvl +: 4]);
    endfunction

    function bit live(int unsigned n);
      return n != 0 && n < NODES;
    endfunction

    function logic [31:0] lookup(logic [LEN_W-1:0] u);
      int unsigned lvl;
      int unsigned cur;
      lvl = depth_of(u);
      cur = root_copy[lvl];
      while (lvl > 0) begin
        if (!live(cur)) return '0;
        cur = node_copy[cur*FANOUT + digit(u, lvl)];
        lvl--;
      end
      if (!live(cur)) return '0;
      return node_copy[cur*FANOUT + digit(u, 0)];
    endfunction

    function int unsigned nodes_missing(logic [LEN_W-1:0] u);
      int unsigned lvl;
      int unsigned cur;
      lvl = depth_of(u);
      cur = root_copy[lvl];
      forever begin
        if (!live(cur)) return lvl + 1;
        if (lvl == 0) return 0;
        cur = node_copy[cur*FANOUT + digit(u, lvl)];
        lvl--;
      end
    endfunction

    function void store(logic [LEN_W-1:0] u, logic [31:0] v);
      int unsigned k;
      int unsigned lvl;
      int unsigned cur;
      int unsigned nxt;
      int unsigned addr;
      k   = depth_of(u);
      cur = root_copy[k];
      if (!live(cur)) begin
        cur = free_node++;
        root_copy[k] = cur;
      end
      for (lvl = k; lvl > 0; lvl--) begin
        addr = cur*FANOUT + digit(u, lvl);
        nxt  = node_copy[addr];
        if (!live(nxt)) begin
          nxt = free_node++;
          node_copy[addr] = nxt;
        end
        cur = nxt;
      end
      node_copy[cur*FANOUT + digit(u, 0)] = v;
    endfunction

    function void note_request(req_t w);
      rsp_t             e;
      logic [LEN_W-1:0] u;
      bit               written;
      e = '0;
      e.status = STATUS_OK;
      u = w.index[LEN_W-1:0];
      if (w.index[31]) begin
        e.status = STATUS_NEG;
      end else if (w.command == CMD_GET) begin
        if (u < length_copy) e.read_value = (u < 16) ? slot_copy[u[3:0]] : lookup(u);
      end else begin
        written = 1'b1;
        if (u < 16) begin
          slot_copy[u[3:0]] = w.write_value;
        end else if (free_node + nodes_missing(u) > NODES) begin
          e.status = STATUS_FULL;
          written  = 1'b0;
        end else begin
          store(u, w.write_value);
        end
        if (written && u >= length_copy) length_copy = (u == LEN_MAX) ? LEN_MAX : u + 31'd1;
      end
      e.current_length = length_copy;
      want_q.push_back(e);
    endfunction

    function void report(string what, longint unsigned want, longint unsigned got);
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (want_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected response word: expected none, actual %0h", $time, got);
        return;
      end
      e = want_q.pop_front();
      if (got.read_value !== e.read_value) report("read_value", e.read_value, got.read_value);
      if (got.status !== e.status) report("status", e.status, got.status);
      if (got.current_length !== e.current_length)
        report("current_length", e.current_length, got.current_length);
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  rtsa_if #(.T(req_t)) req_if ();
  rtsa_if #(.T(rsp_t)) rsp_if ();

  radix_tree_sparse_array_top #(
    .NODE_COUNT(NODES)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  rtsa_scoreboard sb;
  int unsigned    send_idle_pct;
  int unsigned    recv_stall_pct;
  int unsigned    quiet_cycles;
  logic [31:0]    written_q [$];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // accepted words, sampled at the edge; watchdog on cycles with no traffic
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (req_if.valid === 1'b1 && req_if.ready === 1'b1) sb.note_request(req_if.data);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) sb.check_response(rsp_if.data);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  task automatic push_request(command_e c, logic [31:0] idx, logic [31:0] v);
    req_t w;
    w.command     = c;
    w.index       = idx;
    w.write_value = v;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= w;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    if (c == CMD_SET && !idx[31]) written_q.push_back(idx);
  endtask

  function automatic logic [31:0] any_value();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // index whose nibble count is k+1
  function automatic logic [31:0] fresh_index(int unsigned k);
    logic [31:0] u;
    u = $urandom;
    u = u & 32'(((64'h1 << (4*(k+1))) - 1));
    u[4*k +: 4] = (k == 7) ? 4'($urandom_range(1, 7)) : 4'($urandom_range(1, 15));
    return u;
  endfunction

  function automatic logic [31:0] reuse_index();
    logic [31:0] u;
    if (written_q.size() == 0) return $urandom_range(15);
    u = written_q[$urandom_range(written_q.size() - 1)];
    if ($urandom_range(1) == 1) u[3:0] = 4'($urandom_range(15));
    return u;
  endfunction

  task automatic random_phase(int n, int unsigned send_pct, int unsigned stall_pct);
    int unsigned r;
    command_e    c;
    logic [31:0] idx;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 8) begin
        idx = {1'b1, 31'($urandom)};
        c   = command_e'($urandom_range(1));
      end else if (r < 20) begin
        idx = $urandom_range(15);
        c   = command_e'($urandom_range(1));
      end else if (r < 70) begin
        idx = reuse_index();
        c   = ($urandom_range(9) < 6) ? CMD_GET : CMD_SET;
      end else begin
        idx = fresh_index($urandom_range(1, 7));
        c   = ($urandom_range(9) < 6) ? CMD_SET : CMD_GET;
      end
      push_request(c, idx, any_value());
    end
  endtask

  // n deep writes that draw on the node pool, with reads mixed in
  task automatic fill_phase(int n);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    push_request(CMD_SET, 32'h7FFF_FFFF, $urandom);
    push_request(CMD_GET, 32'h7FFF_FFFF, $urandom);
    repeat (n) begin
      if ($urandom_range(4) == 0) push_request(CMD_GET, reuse_index(), $urandom);
      else push_request(CMD_SET, fresh_index(7), any_value());
    end
  endtask

  initial begin
    sb = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni       <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_request(CMD_GET, 32'h0000_0000, 32'h0);
    push_request(CMD_GET, 32'h7FFF_FFFF, 32'h0);
    push_request(CMD_SET, 32'h0000_0000, 32'hFFFF_FFFF);
    push_request(CMD_GET, 32'h0000_0000, 32'h0);
    push_request(CMD_SET, 32'h0000_000F, 32'h0000_0001);
    push_request(CMD_GET, 32'h0000_000F, 32'h0);
    push_request(CMD_GET, 32'h0000_000E, 32'h0);
    push_request(CMD_SET, 32'h0000_0010, 32'hA5A5_A5A5);
    push_request(CMD_GET, 32'h0000_0010, 32'h0);
    push_request(CMD_SET, 32'h0000_00FF, 32'h5A5A_5A5A);
    push_request(CMD_GET, 32'h0000_0020, 32'h0);
    push_request(CMD_GET, 32'h0000_00FF, 32'h0);
    push_request(CMD_SET, 32'h0000_0100, 32'h0000_0000);
    push_request(CMD_GET, 32'h0000_0100, 32'h0);
    push_request(CMD_SET, 32'h0FFF_FFFF, 32'h1234_5678);
    push_request(CMD_GET, 32'h0FFF_FFFF, 32'h0);
    push_request(CMD_GET, 32'h0FFF_FFF0, 32'h0);
    push_request(CMD_GET, 32'h00FF_FFFF, 32'h0);
    push_request(CMD_GET, 32'h0000_1000, 32'h0);
    push_request(CMD_SET, 32'h1000_0000, 32'hDEAD_BEEF);
    push_request(CMD_GET, 32'h1000_0000, 32'h0);
    push_request(CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(CMD_GET, 32'h8000_0000, 32'h0);
    push_request(CMD_SET, 32'h8000_0000, 32'h8000_0001);

    random_phase(160, 0, 0);
    random_phase(160, 50, 0);
    random_phase(160, 0, 50);
    random_phase(160, 34, 34);
    fill_phase(110);
    req_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* radix_tree_sparse_array_top.f */
rtl/rtsa_pkg.sv
rtl/rtsa_if.sv
rtl/radix_tree_sparse_array_top.sv
verif/tb.sv
